[src/bfs_pkg.sv]
package bfs_pkg;

    localparam logic [1:0] OpSet  = 2'd0;
    localparam logic [1:0] OpGet  = 2'd1;
    localparam logic [1:0] OpFill = 2'd2;
    localparam logic [1:0] OpMove = 2'd3;

    // packed widths of the stream beats
    localparam int InBits   = 35;
    localparam int InBytes  = 5;
    localparam int OutBytes = 1;

    typedef struct packed {
        logic signed [7:0] shift_y;
        logic signed [7:0] shift_x;
        logic              pixel_value;
        logic signed [7:0] y_coord;
        logic signed [7:0] x_coord;
        logic [1:0]        opcode;
    } cmd_t;

endpackage

[src/bit_frame_buffer_scroll_unit.sv]
// path: a beat accepted into the input register has its result registered in the result register, which drives m_tdata
// throughput: one beat per cycle while m_tready holds, set by the single pass from input register to result register
// every opcode, move included, completes in that one pass over the flat frame register
// reset: rst_n asynchronous active low, empties both stages and clears every pixel to 0
module bit_frame_buffer_scroll_unit #(
    parameter int WIDTH  = 8,
    parameter int HEIGHT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode[1:0], x_coord[9:2], y_coord[17:10], pixel_value[18],
    // shift_x[26:19], shift_y[34:27], zero fill above
    input  logic [bfs_pkg::InBytes*8-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_out[0], coord_in_range[1], zero fill above
    output logic [bfs_pkg::OutBytes*8-1:0]   m_tdata
);

    // input stage
    logic          in_valid_reg;
    bfs_pkg::cmd_t in_cmd_reg;

    // result stage
    logic          out_valid_reg;
    logic          pixel_reg;
    logic          in_range_reg;

    logic          adv;
    logic          core_pixel;
    logic          core_in_range;

    // result stage moves when empty or when its beat is taken
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= bfs_pkg::cmd_t'(s_tdata[bfs_pkg::InBits-1:0]);
        end
        if (adv && in_valid_reg)
        begin
            pixel_reg    <= core_pixel;
            in_range_reg <= core_in_range;
        end
    end

    // frame store with the per-opcode update; it commits when the beat moves on
    bfs_frame_core #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (in_valid_reg && adv),
        .cmd            (in_cmd_reg),
        .pixel_out      (core_pixel),
        .coord_in_range (core_in_range)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bfs_pkg::OutBytes*8-2){1'b0}}, in_range_reg, pixel_reg};

    a_bubble_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !in_valid_reg) |=> !out_valid_reg)
        else $error("result beat appeared without an input beat");

    a_beat_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_valid_reg) |=> out_valid_reg)
        else $error("input beat lost on the way to the output");

    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("empty input stage refused a beat");

endmodule

[src/bfs_frame_core.sv]
module bfs_frame_core #(
    parameter int WIDTH  = 8,
    parameter int HEIGHT = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  bfs_pkg::cmd_t cmd,
    output logic          pixel_out,
    output logic          coord_in_range
);

    localparam int XW = $clog2(WIDTH);
    localparam int YW = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam logic [7:0] WidthLim  = 8'(WIDTH);
    localparam logic [7:0] HeightLim = 8'(HEIGHT);

    logic [HEIGHT-1:0][WIDTH-1:0] frame_reg;
    logic [HEIGHT-1:0][WIDTH-1:0] frame_next;
    logic [HEIGHT-1:0][WIDTH-1:0] moved;
    logic                         on_frame;
    logic [XW-1:0]                xi;
    logic [YW-1:0]                yi;
    logic [7:0]                   left_amt;

    assign on_frame = !cmd.x_coord[7] && ({1'b0, cmd.x_coord[6:0]} < WidthLim)
                   && !cmd.y_coord[7] && ({1'b0, cmd.y_coord[6:0]} < HeightLim);
    assign xi = cmd.x_coord[XW-1:0];
    assign yi = cmd.y_coord[YW-1:0];

    // negative column offset turns into a left shift by its magnitude
    assign left_amt = 8'(~cmd.shift_x) + 8'd1;

    always_comb
    begin
        logic [8:0]       sy;
        logic [WIDTH-1:0] src;
        for (int r = 0; r < HEIGHT; r++)
        begin
            sy  = 9'(r) + {cmd.shift_y[7], cmd.shift_y};
            src = frame_reg[sy[YW-1:0]];
            if (sy[8] || (sy[7:0] >= HeightLim))
            begin
                moved[r] = '0;
            end
            else if (cmd.shift_x[7])
            begin
                moved[r] = src << left_amt;
            end
            else
            begin
                moved[r] = src >> $unsigned(cmd.shift_x);
            end
        end
    end

    always_comb
    begin
        frame_next = frame_reg;
        unique case (cmd.opcode)
            bfs_pkg::OpSet:
            begin
                if (on_frame)
                begin
                    frame_next[yi][xi] = cmd.pixel_value;
                end
            end
            bfs_pkg::OpGet:  frame_next = frame_reg;
            bfs_pkg::OpFill: frame_next = {(HEIGHT*WIDTH){cmd.pixel_value}};
            bfs_pkg::OpMove: frame_next = moved;
            default:         frame_next = frame_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (en)
        begin
            frame_reg <= frame_next;
        end
    end

    assign pixel_out      = (cmd.opcode == bfs_pkg::OpGet) && on_frame && frame_reg[yi][xi];
    assign coord_in_range = ((cmd.opcode == bfs_pkg::OpSet) || (cmd.opcode == bfs_pkg::OpGet))
                          && on_frame;

    a_get_keeps_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (en && cmd.opcode == bfs_pkg::OpGet) |=> $stable(frame_reg))
        else $error("get pixel changed the frame");

    a_fill_uniform: assert property (@(posedge clk) disable iff (!rst_n)
        (en && cmd.opcode == bfs_pkg::OpFill)
        |=> (frame_reg == {(HEIGHT*WIDTH){$past(cmd.pixel_value)}}))
        else $error("fill left a pixel unchanged");

    a_outside_set_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (en && cmd.opcode == bfs_pkg::OpSet && !on_frame) |=> $stable(frame_reg))
        else $error("set outside the frame wrote a pixel");

endmodule

[dv/bit_frame_buffer_scroll_checker.sv]
module bit_frame_buffer_scroll_checker #(
    parameter int WIDTH  = 8,
    parameter int HEIGHT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [bfs_pkg::InBytes*8-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [bfs_pkg::OutBytes*8-1:0]   m_tdata,
    output int                               error_count,
    output int                               pending_count
);

    import bfs_pkg::*;

    typedef struct packed {
        logic coord_in_range;
        logic pixel_out;
    } pixel_result_t;

    logic [WIDTH-1:0] frame_rows [HEIGHT];
    pixel_result_t    pixel_results_due [$];

    // applies one command to the shadow frame and returns the result it gives
    function automatic pixel_result_t apply_frame_cmd(input cmd_t c);
        int               xi;
        int               yi;
        int               dxi;
        int               dyi;
        int               src_row;
        logic             on_frame;
        logic [63:0]      wide_row;
        logic [WIDTH-1:0] old_rows [HEIGHT];
        pixel_result_t    res;
        xi       = $signed(c.x_coord);
        yi       = $signed(c.y_coord);
        dxi      = $signed(c.shift_x);
        dyi      = $signed(c.shift_y);
        on_frame = (xi >= 0) && (xi < WIDTH) && (yi >= 0) && (yi < HEIGHT);
        res      = '0;
        case (c.opcode)
            OpSet:
            begin
                if (on_frame)
                begin
                    res.coord_in_range = 1'b1;
                    frame_rows[yi][xi] = c.pixel_value;
                end
            end
            OpGet:
            begin
                if (on_frame)
                begin
                    res.coord_in_range = 1'b1;
                    res.pixel_out      = frame_rows[yi][xi];
                end
            end
            OpFill:
            begin
                for (int r = 0; r < HEIGHT; r++)
                    frame_rows[r] = {WIDTH{c.pixel_value}};
            end
            OpMove:
            begin
                old_rows = frame_rows;
                for (int r = 0; r < HEIGHT; r++)
                begin
                    src_row = r + dyi;
                    if (src_row >= 0 && src_row < HEIGHT)
                    begin
                        wide_row = 64'(old_rows[src_row]);
                        // shifts of 64 or more give zero
                        if (dxi >= 0)
                            wide_row = wide_row >> dxi;
                        else
                            wide_row = wide_row << (-dxi);
                        frame_rows[r] = wide_row[WIDTH-1:0];
                    end
                    else
                        frame_rows[r] = '0;
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        pixel_result_t got;
        if (!rst_n)
        begin
            for (int r = 0; r < HEIGHT; r++)
                frame_rows[r] = '0;
            pixel_results_due.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            // result side first: a beat taken now cannot answer this edge
            if (m_tvalid && m_tready)
            begin
                got = pixel_result_t'(m_tdata[1:0]);
                if (pixel_results_due.size() == 0)
                begin
                    $error("result beat with nothing pending: m_tdata %0h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pixel_results_due.pop_front();
                    if (got.pixel_out !== want.pixel_out)
                    begin
                        $error("pixel_out: expected %0d, actual %0d",
                               want.pixel_out, got.pixel_out);
                        error_count++;
                    end
                    if (got.coord_in_range !== want.coord_in_range)
                    begin
                        $error("coord_in_range: expected %0d, actual %0d",
                               want.coord_in_range, got.coord_in_range);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pixel_results_due.push_back(apply_frame_cmd(cmd_t'(s_tdata[InBits-1:0])));
            pending_count = pixel_results_due.size();
        end
    end

endmodule

[dv/tb_bit_frame_buffer_scroll_unit.sv]
module tb_bit_frame_buffer_scroll_unit;

    import bfs_pkg::*;

    localparam int FrameW       = 8;
    localparam int FrameH       = 8;
    localparam int RandomBeats  = 1830;
    localparam int DrainAtBeat  = 400;
    // receiver hold-off window, long enough for the block to back up
    localparam int HoldOffStart = 900;
    localparam int HoldOffEnd   = 1200;
    // window in which neither side idles
    localparam int SteadyStart  = 1600;
    localparam int SteadyEnd    = 2000;
    localparam int CycleLimit   = 200000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    // opcode, x_coord, y_coord, pixel_value, shift_x, shift_y, zero fill above
    logic [InBytes*8-1:0]     s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    // pixel_out, coord_in_range, zero fill above
    logic [OutBytes*8-1:0]    m_tdata;

    int error_count;
    int pending_count;
    int cycle_count = 0;

    bit_frame_buffer_scroll_unit #(
        .WIDTH  (FrameW),
        .HEIGHT (FrameH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow model and scoreboard sit beside the block and only watch
    bit_frame_buffer_scroll_checker #(
        .WIDTH  (FrameW),
        .HEIGHT (FrameH)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // free-running cycle count, also the watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic steady_window();
        return cycle_count >= SteadyStart && cycle_count < SteadyEnd;
    endfunction

    function automatic cmd_t make_cmd(input logic [1:0] op, input int x, input int y,
                                      input logic v, input int dx, input int dy);
        cmd_t c;
        c.opcode      = op;
        c.x_coord     = 8'(x);
        c.y_coord     = 8'(y);
        c.pixel_value = v;
        c.shift_x     = 8'(dx);
        c.shift_y     = 8'(dy);
        return c;
    endfunction

    // mostly on-frame coordinates so that gets see what sets wrote,
    // with full-range values now and then
    function automatic int pick_coord();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, FrameW - 1);
        return $urandom_range(0, 255);
    endfunction

    // small scrolls keep the picture alive, big ones clear it
    function automatic int pick_shift();
        if ($urandom_range(0, 99) < 80)
            return int'($urandom_range(0, 6)) - 3;
        return $urandom_range(0, 255);
    endfunction

    function automatic cmd_t random_cmd();
        int   pick;
        cmd_t c;
        pick = $urandom_range(0, 99);
        // unused fields carry noise
        c = make_cmd(OpSet, $urandom_range(0, 255), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)), $urandom_range(0, 255),
                     $urandom_range(0, 255));
        if (pick < 40)
        begin
            c.opcode  = OpSet;
            c.x_coord = 8'(pick_coord());
            c.y_coord = 8'(pick_coord());
        end
        else if (pick < 75)
        begin
            c.opcode  = OpGet;
            c.x_coord = 8'(pick_coord());
            c.y_coord = 8'(pick_coord());
        end
        else if (pick < 93)
        begin
            c.opcode  = OpMove;
            c.shift_x = 8'(pick_shift());
            c.shift_y = 8'(pick_shift());
        end
        else
            c.opcode = OpFill;
        return c;
    endfunction

    // entered and left at a falling edge; holds the beat until it is taken
    task automatic push_cmd(input cmd_t c);
        while (!steady_window() && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InBytes*8-InBits){1'b0}}, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls, one long hold-off, one stall-free stretch
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (cycle_count >= HoldOffStart && cycle_count < HoldOffEnd)
                m_tready <= 1'b0;
            else if (steady_window())
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 29);
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: cleared frame, fills, edges of the frame, off-frame coordinates
        push_cmd(make_cmd(OpGet, 0, 0, 1'b0, 0, 0));
        push_cmd(make_cmd(OpFill, 0, 0, 1'b1, 0, 0));
        push_cmd(make_cmd(OpGet, 7, 7, 1'b0, 0, 0));
        push_cmd(make_cmd(OpGet, -1, 0, 1'b0, 0, 0));
        push_cmd(make_cmd(OpGet, 8, 0, 1'b0, 0, 0));
        push_cmd(make_cmd(OpGet, 0, 8, 1'b0, 0, 0));
        push_cmd(make_cmd(OpGet, -128, 127, 1'b0, 0, 0));
        push_cmd(make_cmd(OpFill, 0, 0, 1'b0, 0, 0));
        push_cmd(make_cmd(OpSet, 0, 0, 1'b1, 0, 0));
        push_cmd(make_cmd(OpSet, 7, 7, 1'b1, 0, 0));
        push_cmd(make_cmd(OpSet, 7, 0, 1'b1, 0, 0));
        // writes off the frame must leave it untouched
        push_cmd(make_cmd(OpSet, -1, 3, 1'b1, 0, 0));
        push_cmd(make_cmd(OpSet, 127, -128, 1'b1, 0, 0));
        push_cmd(make_cmd(OpGet, 7, 0, 1'b0, 0, 0));
        // small scrolls both ways
        push_cmd(make_cmd(OpMove, 0, 0, 1'b0, 1, 1));
        push_cmd(make_cmd(OpGet, 6, 6, 1'b0, 0, 0));
        push_cmd(make_cmd(OpMove, 0, 0, 1'b0, -2, -1));
        push_cmd(make_cmd(OpGet, 0, 7, 1'b0, 0, 0));
        // offsets that move the whole source off the frame clear it
        push_cmd(make_cmd(OpFill, 0, 0, 1'b1, 0, 0));
        push_cmd(make_cmd(OpMove, 0, 0, 1'b1, 127, 0));
        push_cmd(make_cmd(OpFill, 0, 0, 1'b1, 0, 0));
        push_cmd(make_cmd(OpMove, 0, 0, 1'b1, -128, -128));
        push_cmd(make_cmd(OpFill, 0, 0, 1'b1, 0, 0));
        push_cmd(make_cmd(OpMove, 0, 0, 1'b1, 0, -8));
        push_cmd(make_cmd(OpGet, 3, 3, 1'b0, 0, 0));

        for (int n = 0; n < RandomBeats; n++)
        begin
            if (n == DrainAtBeat)
            begin
                // sender pauses until the block has handed back everything
                s_tvalid <= 1'b0;
                do
                    @(negedge clk);
                while (pending_count != 0);
            end
            push_cmd(random_cmd());
        end
        s_tvalid <= 1'b0;

        // let the pipeline drain, then watch for stray beats
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
